[rtl/core/vpmr_pkg.sv]
// vpmr_pkg: shared constants, codes and types of the planar display memory read path
// used by every file under rtl/core but vpmr_ram; depends on nothing
package vpmr_pkg;

	// plane geometry
	localparam int PLANE_BYTES = 65536;
	localparam int PLANE_AW    = $clog2(PLANE_BYTES);
	localparam int NUM_PLANES  = 4;

	// field widths
	localparam int ADDR_W  = 20;
	localparam int OFF_W   = 17;
	localparam int MODE_W  = 2;
	localparam int PLANE_W = 2;
	localparam int BYTE_W  = 8;
	localparam int DATA_W  = 32;
	localparam int CFG_IW  = 3;

	// address constants
	localparam logic [ADDR_W-1:0] APERTURE_BASE = 20'hA0000;
	localparam logic [ADDR_W-1:0] PLANE_LIMIT   = ADDR_W'(PLANE_BYTES);
	localparam logic [BYTE_W-1:0] BYTE_FF       = 8'hFF;

	// item kinds carried in tuser
	localparam logic [MODE_W-1:0] MODE_LOAD  = 2'd0;
	localparam logic [MODE_W-1:0] MODE_BYTE  = 2'd1;
	localparam logic [MODE_W-1:0] MODE_WORD  = 2'd2;
	localparam logic [MODE_W-1:0] MODE_DWORD = 2'd3;

	// configuration register indexes
	localparam logic [CFG_IW-1:0] CFG_WINDOW_LOW      = 3'd0;
	localparam logic [CFG_IW-1:0] CFG_WINDOW_HIGH     = 3'd1;
	localparam logic [CFG_IW-1:0] CFG_CHAIN4_ENABLE   = 3'd2;
	localparam logic [CFG_IW-1:0] CFG_ODD_EVEN_ENABLE = 3'd3;
	localparam logic [CFG_IW-1:0] CFG_READ_MODE       = 3'd4;
	localparam logic [CFG_IW-1:0] CFG_READ_MAP_SELECT = 3'd5;
	localparam logic [CFG_IW-1:0] CFG_COLOR_COMPARE   = 3'd6;
	localparam logic [CFG_IW-1:0] CFG_COLOR_DONT_CARE = 3'd7;

	// configuration reset values
	localparam logic [ADDR_W-1:0] WINDOW_LOW_RESET  = 20'hA0000;
	localparam logic [ADDR_W-1:0] WINDOW_HIGH_RESET = 20'hBFFFF;
	localparam logic [3:0]        DONT_CARE_RESET   = 4'hF;

	// queue between front and back
	localparam int QUEUE_DEPTH = 2;
	localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

	typedef struct packed {
		logic [ADDR_W-1:0] window_low;
		logic [ADDR_W-1:0] window_high;
		logic              chain4;
		logic              odd_even;
		logic              read_mode;
		logic [1:0]        read_map_select;
		logic [3:0]        color_compare;
		logic [3:0]        color_dont_care;
	} cfg_t;

	// one classified item as held in the queue
	typedef struct packed {
		logic               is_load;
		logic               load_ok;
		logic [1:0]         last_byte;
		logic [OFF_W-1:0]   offset;
		logic [PLANE_W-1:0] plane;
		logic [BYTE_W-1:0]  data;
	} item_t;

endpackage

[rtl/core/vpmr_front.sv]
// vpmr_front: accepts input transactions, classifies them and holds them in a short queue
// depends on vpmr_pkg
module vpmr_front (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         s_axis_tvalid,
	output logic                         s_axis_tready,
	// tdata: offset[16:0], load_plane[18:17], load_data[26:19], zero[31:27]
	input  logic [31:0]                  s_axis_tdata,
	// tuser: mode[1:0]
	input  logic [vpmr_pkg::MODE_W-1:0]  s_axis_tuser,
	output logic                         q_valid,
	output vpmr_pkg::item_t              q_item,
	input  logic                         q_pop
);

	vpmr_pkg::item_t                  entry_q [vpmr_pkg::QUEUE_DEPTH];
	logic [vpmr_pkg::QUEUE_AW-1:0]    wr_ptr_q;
	logic [vpmr_pkg::QUEUE_AW-1:0]    rd_ptr_q;
	logic [vpmr_pkg::QUEUE_AW:0]      count_q;
	vpmr_pkg::item_t                  item_c;
	logic                             push;

	assign s_axis_tready = count_q != (vpmr_pkg::QUEUE_AW+1)'(vpmr_pkg::QUEUE_DEPTH);
	assign push          = s_axis_tvalid && s_axis_tready;
	assign q_valid       = count_q != '0;
	assign q_item        = entry_q[rd_ptr_q];

	// classify the incoming item
	always_comb begin
		item_c.offset  = s_axis_tdata[16:0];
		item_c.plane   = s_axis_tdata[18:17];
		item_c.data    = s_axis_tdata[26:19];
		item_c.is_load = s_axis_tuser == vpmr_pkg::MODE_LOAD;
		item_c.load_ok = {3'b000, s_axis_tdata[16:0]} < vpmr_pkg::PLANE_LIMIT;
		case (s_axis_tuser)
			vpmr_pkg::MODE_BYTE:  item_c.last_byte = 2'd0;
			vpmr_pkg::MODE_WORD:  item_c.last_byte = 2'd1;
			vpmr_pkg::MODE_DWORD: item_c.last_byte = 2'd3;
			default:              item_c.last_byte = 2'd0;
		endcase
	end

	// queue storage
	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= item_c;
		end
	end

	// queue pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (q_pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !q_pop) begin
				count_q <= count_q + 1'b1;
			end else if (!push && q_pop) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

[rtl/core/vpmr_ram.sv]
// vpmr_ram: generic simple dual-port RAM with registered read
// depends on nothing
module vpmr_ram #(
	parameter int  WIDTH = 8,
	parameter int  DEPTH = 16,
	localparam int AW    = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// write port and registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

[rtl/core/vpmr_back.sv]
// vpmr_back: byte sequencer, window decode, plane RAMs, read latches and result register
// depends on vpmr_pkg and vpmr_ram
module vpmr_back (
	input  logic                         clk,
	input  logic                         arst_n,
	input  vpmr_pkg::cfg_t               cfg,
	input  logic                         q_valid,
	input  vpmr_pkg::item_t              q_item,
	output logic                         q_pop,
	output logic                         m_axis_tvalid,
	input  logic                         m_axis_tready,
	// tdata: read_data[31:0]
	output logic [vpmr_pkg::DATA_W-1:0]  m_axis_tdata
);

	// how a byte gets its value once plane data is back
	localparam logic [1:0] KIND_FF         = 2'd0;
	localparam logic [1:0] KIND_DIRECT     = 2'd1;
	localparam logic [1:0] KIND_LATCH_LOAD = 2'd2;
	localparam logic [1:0] KIND_LATCH_HOLD = 2'd3;

	localparam int AW = vpmr_pkg::ADDR_W;
	localparam int PW = vpmr_pkg::PLANE_AW;
	localparam int BW = vpmr_pkg::BYTE_W;

	// item being sequenced
	logic                     busy_q;
	logic [1:0]               k_q;
	vpmr_pkg::item_t          item_q;
	logic                     read_inflight_q;
	logic                     final_byte;
	logic                     free;

	// stage 1: absolute address
	logic                     valid_s1;
	logic                     load_s1;
	logic                     past_s1;
	logic [AW-1:0]            abs_s1;
	logic [1:0]               k_s1;
	logic                     last_s1;
	logic                     ld_ok_s1;
	logic [1:0]               ld_plane_s1;
	logic [BW-1:0]            ld_data_s1;
	logic [PW-1:0]            ld_addr_s1;
	logic [vpmr_pkg::OFF_W:0] sum;

	// stage 2: window relative address, plane access
	logic                     valid_s2;
	logic                     load_s2;
	logic                     bad_s2;
	logic [AW-1:0]            rel_s2;
	logic [1:0]               k_s2;
	logic                     last_s2;
	logic                     ld_ok_s2;
	logic [1:0]               ld_plane_s2;
	logic [BW-1:0]            ld_data_s2;
	logic [PW-1:0]            ld_addr_s2;
	logic [AW-1:0]            half;
	logic [AW-1:0]            idx_c4;
	logic [AW-1:0]            idx_oe;
	logic                     low_half;
	logic [AW-1:0]            idx_sel;
	logic [1:0]               kind_c;
	logic [1:0]               plane_c;
	logic                     rd_en;

	// stage 3: plane data back
	logic                     valid_s3;
	logic [1:0]               kind_s3;
	logic [1:0]               plane_s3;
	logic [1:0]               k_s3;
	logic                     last_s3;
	logic [BW-1:0]            rdata [vpmr_pkg::NUM_PLANES];
	logic [BW-1:0]            latch_q [vpmr_pkg::NUM_PLANES];
	logic [BW-1:0]            latch_c [vpmr_pkg::NUM_PLANES];
	logic [BW-1:0]            byte_c;
	logic [vpmr_pkg::DATA_W-1:0] word_c;
	logic [vpmr_pkg::DATA_W-1:0] acc_q;
	logic                     done;

	// result register
	logic                     out_valid_q;
	logic [vpmr_pkg::DATA_W-1:0] out_data_q;

	// colour compare over the eight pixels of the latches
	function automatic logic [BW-1:0] color_match(input logic [BW-1:0] l0, input logic [BW-1:0] l1,
			input logic [BW-1:0] l2, input logic [BW-1:0] l3, input logic [3:0] cmp,
			input logic [3:0] dc);
		logic [BW-1:0] res;
		logic [3:0]    colour;
		for (int b = 0; b < BW; b++) begin
			colour = {l3[b], l2[b], l1[b], l0[b]};
			res[b] = (colour & dc) == (cmp & dc);
		end
		return res;
	endfunction

	// issue control: a read waits until no other result is pending
	assign final_byte = k_q == item_q.last_byte;
	assign free       = !busy_q || final_byte;
	assign q_pop      = q_valid && free && (q_item.is_load ||
		(!read_inflight_q && (!out_valid_q || m_axis_tready)));
	assign done       = valid_s3 && last_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q          <= 1'b0;
			k_q             <= 2'd0;
			read_inflight_q <= 1'b0;
		end else begin
			if (q_pop) begin
				busy_q <= 1'b1;
				k_q    <= 2'd0;
			end else if (busy_q) begin
				if (final_byte) begin
					busy_q <= 1'b0;
				end else begin
					k_q <= k_q + 2'd1;
				end
			end
			if (q_pop && !q_item.is_load) begin
				read_inflight_q <= 1'b1;
			end else if (done) begin
				read_inflight_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop) begin
			item_q <= q_item;
		end
	end

	// stage 1: byte offset and absolute address
	assign sum = {1'b0, item_q.offset} + {{(vpmr_pkg::OFF_W-1){1'b0}}, k_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= busy_q;
		end
	end

	always_ff @(posedge clk) begin
		load_s1     <= item_q.is_load;
		past_s1     <= sum[vpmr_pkg::OFF_W];
		abs_s1      <= vpmr_pkg::APERTURE_BASE +
			{{(AW-vpmr_pkg::OFF_W){1'b0}}, sum[vpmr_pkg::OFF_W-1:0]};
		k_s1        <= k_q;
		last_s1     <= final_byte;
		ld_ok_s1    <= item_q.load_ok;
		ld_plane_s1 <= item_q.plane;
		ld_data_s1  <= item_q.data;
		ld_addr_s1  <= item_q.offset[PW-1:0];
	end

	// stage 2: window check and relative address
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		load_s2     <= load_s1;
		bad_s2      <= past_s1 || (abs_s1 < cfg.window_low) || (abs_s1 > cfg.window_high);
		rel_s2      <= abs_s1 - cfg.window_low;
		k_s2        <= k_s1;
		last_s2     <= last_s1;
		ld_ok_s2    <= ld_ok_s1;
		ld_plane_s2 <= ld_plane_s1;
		ld_data_s2  <= ld_data_s1;
		ld_addr_s2  <= ld_addr_s1;
	end

	// plane and index by addressing mode
	always_comb begin
		half     = {1'b0, rel_s2[AW-1:1]};
		idx_c4   = {2'b00, rel_s2[AW-1:2]};
		low_half = half < vpmr_pkg::PLANE_LIMIT;
		idx_oe   = low_half ? half : half - vpmr_pkg::PLANE_LIMIT;
		kind_c   = KIND_FF;
		plane_c  = 2'd0;
		idx_sel  = rel_s2;
		if (!bad_s2) begin
			if (cfg.chain4) begin
				plane_c = rel_s2[1:0];
				idx_sel = idx_c4;
				if (idx_c4 < vpmr_pkg::PLANE_LIMIT) begin
					kind_c = KIND_DIRECT;
				end
			end else if (cfg.odd_even) begin
				plane_c = {!low_half, rel_s2[0]};
				idx_sel = idx_oe;
				if (idx_oe < vpmr_pkg::PLANE_LIMIT) begin
					kind_c = KIND_DIRECT;
				end
			end else if (rel_s2 < vpmr_pkg::PLANE_LIMIT) begin
				kind_c = KIND_LATCH_LOAD;
			end else begin
				kind_c = KIND_LATCH_HOLD;
			end
		end
	end

	assign rd_en = valid_s2 && !load_s2 && (kind_c == KIND_DIRECT || kind_c == KIND_LATCH_LOAD);

	// plane memories, one per plane, sharing the read address
	for (genvar p = 0; p < vpmr_pkg::NUM_PLANES; p++) begin : g_plane
		vpmr_ram #(
			.WIDTH(BW),
			.DEPTH(vpmr_pkg::PLANE_BYTES)
		) u_plane_ram (
			.clk  (clk),
			.we   (valid_s2 && load_s2 && ld_ok_s2 && ld_plane_s2 == 2'(p)),
			.waddr(ld_addr_s2),
			.wdata(ld_data_s2),
			.re   (rd_en),
			.raddr(idx_sel[PW-1:0]),
			.rdata(rdata[p])
		);
	end

	// stage 3: loads end at stage 2
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3 <= 1'b0;
		end else begin
			valid_s3 <= valid_s2 && !load_s2;
		end
	end

	always_ff @(posedge clk) begin
		kind_s3  <= kind_c;
		plane_s3 <= plane_c;
		k_s3     <= k_s2;
		last_s3  <= last_s2;
	end

	// latch update and byte value
	always_comb begin
		for (int p = 0; p < vpmr_pkg::NUM_PLANES; p++) begin
			latch_c[p] = (kind_s3 == KIND_LATCH_LOAD) ? rdata[p] : latch_q[p];
		end
		case (kind_s3)
			KIND_FF:     byte_c = vpmr_pkg::BYTE_FF;
			KIND_DIRECT: byte_c = rdata[plane_s3];
			default: begin
				if (cfg.read_mode) begin
					byte_c = color_match(latch_c[0], latch_c[1], latch_c[2], latch_c[3],
						cfg.color_compare, cfg.color_dont_care);
				end else begin
					byte_c = latch_c[cfg.read_map_select];
				end
			end
		endcase
		word_c = ((k_s3 == 2'd0) ? '0 : acc_q) |
			({{(vpmr_pkg::DATA_W-BW){1'b0}}, byte_c} << {k_s3, 3'b000});
	end

	// read latches
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int p = 0; p < vpmr_pkg::NUM_PLANES; p++) begin
				latch_q[p] <= '0;
			end
		end else if (valid_s3) begin
			for (int p = 0; p < vpmr_pkg::NUM_PLANES; p++) begin
				latch_q[p] <= latch_c[p];
			end
		end
	end

	// byte assembly and result register
	always_ff @(posedge clk) begin
		if (valid_s3) begin
			acc_q <= word_c;
		end
		if (done) begin
			out_data_q <= word_c;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (done) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = out_data_q;

	// a finished read never lands on a result that is still waiting
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (!out_valid_q || m_axis_tready))
		else $error("result register overwritten");

	// byte counter stays within the access size
	a_k_bound: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q |-> (k_q <= item_q.last_byte))
		else $error("byte counter past access size");

	// a read byte in the last stage belongs to a read that is tracked as pending
	a_inflight: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s3 |-> read_inflight_q)
		else $error("read byte without pending read");

	// a read is started only while no other read is pending
	a_single_read: assert property (@(posedge clk) disable iff (!arst_n)
		(q_pop && !q_item.is_load) |=> (read_inflight_q && !$past(read_inflight_q)))
		else $error("second read started while one pending");

endmodule

[rtl/core/vga_planar_memory_read_core.sv]
// vga_planar_memory_read_core: top level of the four-plane display memory read path
// depends on vpmr_pkg, vpmr_front, vpmr_back (which holds the vpmr_ram plane memories)
//
// Host read path of a four-plane display memory. Input transactions carry a mode in tuser
// (load byte, read byte, word or dword) and offset, plane and data in tdata; each read gives one
// output transaction, a load gives none. Inputs enter a two-entry queue, so the input side keeps
// accepting while the back end works, until the queue is full. A read of n bytes issues one byte
// per cycle into a three-stage path (absolute address, window check and plane RAM read of all
// four planes at one address, latch update and colour compare); the result is registered in the
// output register once its last byte leaves the path; the next read starts only when no read is
// pending and the output register is empty or being taken. Loads may follow a read without waiting.
// Plane memory is four RAMs of PLANE_BYTES bytes, not cleared at reset; the read latches reset to
// zero. The user must write configuration only while the block is idle; the block does not enforce it.
module vga_planar_memory_read_core (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         s_axis_tvalid,
	output logic                         s_axis_tready,
	// tdata: offset[16:0], load_plane[18:17], load_data[26:19], zero[31:27]
	input  logic [31:0]                  s_axis_tdata,
	// tuser: mode[1:0]
	input  logic [vpmr_pkg::MODE_W-1:0]  s_axis_tuser,
	output logic                         m_axis_tvalid,
	input  logic                         m_axis_tready,
	// tdata: read_data[31:0]
	output logic [vpmr_pkg::DATA_W-1:0]  m_axis_tdata,
	input  logic                         cfg_we,
	input  logic [vpmr_pkg::CFG_IW-1:0]  cfg_index,
	input  logic [vpmr_pkg::ADDR_W-1:0]  cfg_data
);

	vpmr_pkg::cfg_t  cfg_q;
	logic            q_valid;
	vpmr_pkg::item_t q_item;
	logic            q_pop;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.window_low      <= vpmr_pkg::WINDOW_LOW_RESET;
			cfg_q.window_high     <= vpmr_pkg::WINDOW_HIGH_RESET;
			cfg_q.chain4          <= 1'b0;
			cfg_q.odd_even        <= 1'b0;
			cfg_q.read_mode       <= 1'b0;
			cfg_q.read_map_select <= 2'd0;
			cfg_q.color_compare   <= 4'd0;
			cfg_q.color_dont_care <= vpmr_pkg::DONT_CARE_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				vpmr_pkg::CFG_WINDOW_LOW:      cfg_q.window_low      <= cfg_data;
				vpmr_pkg::CFG_WINDOW_HIGH:     cfg_q.window_high     <= cfg_data;
				vpmr_pkg::CFG_CHAIN4_ENABLE:   cfg_q.chain4          <= cfg_data[0];
				vpmr_pkg::CFG_ODD_EVEN_ENABLE: cfg_q.odd_even        <= cfg_data[0];
				vpmr_pkg::CFG_READ_MODE:       cfg_q.read_mode       <= cfg_data[0];
				vpmr_pkg::CFG_READ_MAP_SELECT: cfg_q.read_map_select <= cfg_data[1:0];
				vpmr_pkg::CFG_COLOR_COMPARE:   cfg_q.color_compare   <= cfg_data[3:0];
				vpmr_pkg::CFG_COLOR_DONT_CARE: cfg_q.color_dont_care <= cfg_data[3:0];
				default: ;
			endcase
		end
	end

	// accept and queue
	vpmr_front u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata (s_axis_tdata),
		.s_axis_tuser (s_axis_tuser),
		.q_valid      (q_valid),
		.q_item       (q_item),
		.q_pop        (q_pop)
	);

	// execute loads and reads
	vpmr_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg          (cfg_q),
		.q_valid      (q_valid),
		.q_item       (q_item),
		.q_pop        (q_pop),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata (m_axis_tdata)
	);

endmodule

[sim/vga_planar_memory_read_core_checker.sv]
// vga_planar_memory_read_core_checker: watches the stream and configuration ports of the
// planar display memory read core, predicts each read result and compares it; uses vpmr_pkg
module vga_planar_memory_read_core_checker (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         s_axis_tvalid,
	input  logic                         s_axis_tready,
	// tdata: offset[16:0], load_plane[18:17], load_data[26:19], zero[31:27]
	input  logic [31:0]                  s_axis_tdata,
	// tuser: mode[1:0]
	input  logic [vpmr_pkg::MODE_W-1:0]  s_axis_tuser,
	input  logic                         m_axis_tvalid,
	input  logic                         m_axis_tready,
	// tdata: read_data[31:0]
	input  logic [vpmr_pkg::DATA_W-1:0]  m_axis_tdata,
	input  logic                         cfg_we,
	input  logic [vpmr_pkg::CFG_IW-1:0]  cfg_index,
	input  logic [vpmr_pkg::ADDR_W-1:0]  cfg_data,
	output int                           errors,
	output int                           pending
);
	import vpmr_pkg::*;

	localparam int APERTURE_BYTES = 'h20000;

	cfg_t              settings;
	logic [BYTE_W-1:0] plane_image [0:NUM_PLANES*PLANE_BYTES-1];
	logic [BYTE_W-1:0] latches [0:NUM_PLANES-1];
	logic [DATA_W-1:0] expected_reads [$];
	logic [DATA_W-1:0] oldest;

	initial errors = 0;

	task automatic report(input string what);
		$display("%0t mismatch: %s", $time, what);
		errors++;
	endtask

	function automatic logic [BYTE_W-1:0] plane_byte(input int plane, input int idx);
		if (idx >= PLANE_BYTES)
			return BYTE_FF;
		return plane_image[plane * PLANE_BYTES + idx];
	endfunction

	// one byte of a host read; a planar access inside the plane refreshes the latches
	function automatic logic [BYTE_W-1:0] read_byte(input int off);
		int                abs_a;
		int                rel;
		logic [3:0]        colour;
		logic [BYTE_W-1:0] mask;
		abs_a = int'(APERTURE_BASE) + off;
		if (off >= APERTURE_BYTES || abs_a < int'(settings.window_low) ||
				abs_a > int'(settings.window_high))
			return BYTE_FF;
		rel = abs_a - int'(settings.window_low);
		if (settings.chain4)
			return plane_byte(rel % 4, rel / 4);
		if (settings.odd_even) begin
			if (rel / 2 < PLANE_BYTES)
				return plane_byte(rel % 2, rel / 2);
			return plane_byte(2 + rel % 2, rel / 2 - PLANE_BYTES);
		end
		if (rel < PLANE_BYTES)
			for (int p = 0; p < NUM_PLANES; p++)
				latches[p] = plane_image[p * PLANE_BYTES + rel];
		if (!settings.read_mode)
			return latches[settings.read_map_select];
		// colour compare: one bit per pixel, colour taken across the four latches
		for (int b = 0; b < BYTE_W; b++) begin
			colour = {latches[3][b], latches[2][b], latches[1][b], latches[0][b]};
			mask[b] = ((colour ^ settings.color_compare) & settings.color_dont_care) == 4'd0;
		end
		return mask;
	endfunction

	// loads update the plane image, reads queue the expected result
	task automatic take_item(input logic [MODE_W-1:0] kind, input logic [31:0] word);
		logic [OFF_W-1:0]  off;
		logic [PLANE_W-1:0] plane;
		logic [DATA_W-1:0] value;
		int                n;
		off = word[OFF_W-1:0];
		plane = word[OFF_W +: PLANE_W];
		if (kind == MODE_LOAD) begin
			if (off < PLANE_BYTES)
				plane_image[int'(plane) * PLANE_BYTES + int'(off)] =
					word[OFF_W+PLANE_W +: BYTE_W];
		end else begin
			n = (kind == MODE_BYTE) ? 1 : (kind == MODE_WORD) ? 2 : 4;
			value = '0;
			for (int k = 0; k < n; k++)
				value[8*k +: 8] = read_byte(int'(off) + k);
			expected_reads.push_back(value);
		end
	endtask

	// sample all channels at the rising edge
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			settings = '0;
			settings.window_low = WINDOW_LOW_RESET;
			settings.window_high = WINDOW_HIGH_RESET;
			settings.color_dont_care = DONT_CARE_RESET;
			for (int p = 0; p < NUM_PLANES; p++)
				latches[p] = '0;
			expected_reads.delete();
			pending = 0;
		end else begin
			// register write
			if (cfg_we) begin
				case (cfg_index)
					CFG_WINDOW_LOW:      settings.window_low = cfg_data;
					CFG_WINDOW_HIGH:     settings.window_high = cfg_data;
					CFG_CHAIN4_ENABLE:   settings.chain4 = cfg_data[0];
					CFG_ODD_EVEN_ENABLE: settings.odd_even = cfg_data[0];
					CFG_READ_MODE:       settings.read_mode = cfg_data[0];
					CFG_READ_MAP_SELECT: settings.read_map_select = cfg_data[1:0];
					CFG_COLOR_COMPARE:   settings.color_compare = cfg_data[3:0];
					CFG_COLOR_DONT_CARE: settings.color_dont_care = cfg_data[3:0];
					default: ;
				endcase
			end
			// result transaction against the oldest expected read
			if (m_axis_tvalid && m_axis_tready) begin
				if (expected_reads.size() == 0) begin
					report($sformatf("read_data %h with no read outstanding", m_axis_tdata));
				end else begin
					oldest = expected_reads.pop_front();
					if (m_axis_tdata !== oldest)
						report($sformatf("read_data %h, expected %h", m_axis_tdata, oldest));
				end
			end
			// input transaction
			if (s_axis_tvalid && s_axis_tready)
				take_item(s_axis_tuser, s_axis_tdata);
			pending = expected_reads.size();
		end
	end

endmodule

[sim/vga_planar_memory_read_core_tb.sv]
// vga_planar_memory_read_core_tb: stimulus and verdict for the planar display memory read core
// depends on vpmr_pkg, vga_planar_memory_read_core and vga_planar_memory_read_core_checker
module vga_planar_memory_read_core_tb;
	import vpmr_pkg::*;

	localparam int CYCLE_LIMIT    = 400000;
	localparam int IDLE_PCT       = 27;
	localparam int PHASES         = 9;
	localparam int TOTAL_ITEMS    = 450;
	localparam int HOLD_CYCLES    = 300;
	localparam int DRAIN_CYCLES   = 12;
	localparam int APERTURE_BYTES = 'h20000;

	logic                clk = 1'b0;
	logic                arst_n = 1'b0;
	logic                s_axis_tvalid = 1'b0;
	logic                s_axis_tready;
	logic [31:0]         s_axis_tdata = '0;
	logic [MODE_W-1:0]   s_axis_tuser = MODE_LOAD;
	logic                m_axis_tvalid;
	logic                m_axis_tready = 1'b0;
	logic [DATA_W-1:0]   m_axis_tdata;
	logic                cfg_we = 1'b0;
	logic [CFG_IW-1:0]   cfg_index = CFG_WINDOW_LOW;
	logic [ADDR_W-1:0]   cfg_data = '0;

	int   errors;
	int   pending;
	int   cycles = 0;
	int   reads_sent = 0;
	int   items_sent = 0;
	bit   steady = 1'b0;
	bit   sink_hold = 1'b0;
	cfg_t shadow;
	bit   loaded [0:NUM_PLANES*PLANE_BYTES-1];

	vga_planar_memory_read_core dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data)
	);

	vga_planar_memory_read_core_checker read_check (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.errors        (errors),
		.pending       (pending)
	);

	initial begin
		forever #6 clk = ~clk;
	end

	// run-away guard
	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("vga_planar_memory_read_core_tb failed");
			$finish;
		end
	end

	// result sink with random stalls
	always @(negedge clk)
		m_axis_tready <= !sink_hold && (steady || $urandom_range(0, 99) >= IDLE_PCT);

	// one long sink hold-off while the source keeps offering, so the input backs up
	initial begin
		wait (reads_sent >= 40);
		@(negedge clk);
		sink_hold <= 1'b1;
		repeat (HOLD_CYCLES) @(negedge clk);
		sink_hold <= 1'b0;
	end

	// offer one input transaction and wait for it to be taken
	task automatic offer(input logic [MODE_W-1:0] kind, input logic [OFF_W-1:0] off,
			input logic [PLANE_W-1:0] plane, input logic [BYTE_W-1:0] data);
		if (!steady) begin
			while ($urandom_range(0, 99) < IDLE_PCT) begin
				s_axis_tvalid <= 1'b0;
				@(negedge clk);
			end
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tuser <= kind;
		s_axis_tdata <= {5'd0, data, plane, off};
		do
			@(posedge clk);
		while (!s_axis_tready);
		items_sent++;
		@(negedge clk);
	endtask

	task automatic store(input int off, input int plane, input int data);
		offer(MODE_LOAD, OFF_W'(off), PLANE_W'(plane), BYTE_W'(data));
		if (off < PLANE_BYTES)
			loaded[plane * PLANE_BYTES + off] = 1'b1;
	endtask

	// load every plane byte that a one-byte read at off would fetch, if not yet written
	task automatic prime_byte(input int off);
		int abs_a;
		int rel;
		int plane;
		int idx;
		abs_a = int'(APERTURE_BASE) + off;
		plane = -1;
		idx = 0;
		if (off < APERTURE_BYTES && abs_a >= int'(shadow.window_low) &&
				abs_a <= int'(shadow.window_high)) begin
			rel = abs_a - int'(shadow.window_low);
			if (shadow.chain4) begin
				plane = rel % 4;
				idx = rel / 4;
			end else if (shadow.odd_even) begin
				plane = rel % 2;
				idx = rel / 2;
				if (idx >= PLANE_BYTES) begin
					plane += 2;
					idx -= PLANE_BYTES;
				end
			end else if (rel < PLANE_BYTES) begin
				// planar: all four planes at once
				plane = NUM_PLANES;
				idx = rel;
			end
		end
		if (plane == NUM_PLANES) begin
			for (int p = 0; p < NUM_PLANES; p++)
				if (!loaded[p * PLANE_BYTES + idx])
					store(idx, p, $urandom_range(0, 255));
		end else if (plane >= 0 && idx < PLANE_BYTES && !loaded[plane * PLANE_BYTES + idx]) begin
			store(idx, plane, $urandom_range(0, 255));
		end
	endtask

	task automatic issue_read(input logic [MODE_W-1:0] kind, input int off);
		int n;
		n = (kind == MODE_BYTE) ? 1 : (kind == MODE_WORD) ? 2 : 4;
		for (int k = 0; k < n; k++)
			prime_byte(off + k);
		offer(kind, OFF_W'(off), PLANE_W'($urandom_range(0, 3)), BYTE_W'($urandom_range(0, 255)));
		reads_sent++;
	endtask

	task automatic write_reg(input logic [CFG_IW-1:0] idx, input logic [ADDR_W-1:0] value);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		@(negedge clk);
	endtask

	task automatic apply(input cfg_t c);
		write_reg(CFG_WINDOW_LOW, c.window_low);
		write_reg(CFG_WINDOW_HIGH, c.window_high);
		write_reg(CFG_CHAIN4_ENABLE, ADDR_W'(c.chain4));
		write_reg(CFG_ODD_EVEN_ENABLE, ADDR_W'(c.odd_even));
		write_reg(CFG_READ_MODE, ADDR_W'(c.read_mode));
		write_reg(CFG_READ_MAP_SELECT, ADDR_W'(c.read_map_select));
		write_reg(CFG_COLOR_COMPARE, ADDR_W'(c.color_compare));
		write_reg(CFG_COLOR_DONT_CARE, ADDR_W'(c.color_dont_care));
		cfg_we <= 1'b0;
		shadow = c;
	endtask

	// wait until every read has returned and trailing loads have drained
	task automatic settle;
		s_axis_tvalid <= 1'b0;
		while (pending != 0)
			@(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
	endtask

	function automatic cfg_t pick_settings(input int ph);
		cfg_t c;
		c.window_low = ADDR_W'(20'hA0000 + (($urandom_range(0, 2) == 0) ?
			$urandom_range(0, 'h1FFFF) : $urandom_range(0, 'h3FF)));
		c.window_high = ADDR_W'(20'hBFFFF - (($urandom_range(0, 2) == 0) ?
			$urandom_range(0, 'h1FFFF) : $urandom_range(0, 'h3FF)));
		c.chain4 = 1'($urandom_range(0, 1));
		c.odd_even = 1'($urandom_range(0, 1));
		c.read_mode = 1'($urandom_range(0, 1));
		c.read_map_select = 2'($urandom_range(0, 3));
		c.color_compare = 4'($urandom_range(0, 15));
		c.color_dont_care = 4'($urandom_range(0, 15));
		case (ph)
			0: begin
				c = '0;
				c.window_low = WINDOW_LOW_RESET;
				c.window_high = WINDOW_HIGH_RESET;
				c.color_dont_care = DONT_CARE_RESET;
			end
			1: begin
				c.window_low = WINDOW_LOW_RESET;
				c.window_high = WINDOW_HIGH_RESET;
				c.chain4 = 1'b1;
			end
			2: begin
				// inverted window: nothing decodes
				c.window_low = 20'hBFFFF;
				c.window_high = 20'hA0000;
			end
			3: begin
				c.chain4 = 1'b0;
				c.odd_even = 1'b1;
			end
			4: begin
				c.chain4 = 1'b0;
				c.odd_even = 1'b0;
				c.read_mode = 1'b1;
				c.read_map_select = 2'd3;
				c.color_compare = 4'hF;
				c.color_dont_care = 4'hF;
			end
			5: begin
				// empty compare mask: every pixel matches
				c.chain4 = 1'b0;
				c.odd_even = 1'b0;
				c.read_mode = 1'b1;
				c.color_compare = 4'h0;
				c.color_dont_care = 4'h0;
			end
			6: begin
				c.chain4 = 1'b0;
				c.odd_even = 1'b0;
				c.window_low = WINDOW_LOW_RESET + 20'h8000;
			end
			default: ;
		endcase
		return c;
	endfunction

	// read offsets, mostly near the window start, the aperture end and the window edges
	function automatic int pick_offset();
		int base;
		base = int'(shadow.window_low) - int'(APERTURE_BASE);
		case ($urandom_range(0, 9))
			0, 1, 2, 3: return (base + $urandom_range(0, 63)) & 'h1FFFF;
			4:          return 'h1FFF8 + $urandom_range(0, 7);
			5:          return (base + $urandom_range(0, 4) - 3) & 'h1FFFF;
			6:          return (int'(shadow.window_high) - int'(APERTURE_BASE) +
				$urandom_range(0, 4) - 2) & 'h1FFFF;
			default:    return $urandom_range(0, 'h1FFFF);
		endcase
	endfunction

	initial begin
		cfg_t c;
		int   ph;
		int   kind;
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// directed: reset settings, planar plane select
		c = pick_settings(0);
		apply(c);
		store(0, 0, 'h00);
		store(0, 1, 'hFF);
		store(0, 2, 'hA5);
		store(0, 3, 'h5A);
		issue_read(MODE_BYTE, 0);
		// load past the plane is dropped
		store('h1FFFF, 3, 'hFF);
		store('h0FFFF, 3, 'hFF);
		// second byte lies beyond the plane and keeps the latches
		issue_read(MODE_WORD, 'h0FFFF);
		// tail bytes past the aperture
		issue_read(MODE_DWORD, 'h1FFFE);
		issue_read(MODE_BYTE, 'h1FFFF);
		settle;

		// directed: narrow window, colour compare, then chain-4 and odd/even
		c.window_low = 20'hA0010;
		c.window_high = 20'hA001F;
		c.read_mode = 1'b1;
		c.read_map_select = 2'd2;
		c.color_compare = 4'hA;
		apply(c);
		issue_read(MODE_DWORD, 'h0E);
		issue_read(MODE_DWORD, 'h1E);
		issue_read(MODE_BYTE, 'h14);
		settle;
		c.chain4 = 1'b1;
		apply(c);
		issue_read(MODE_DWORD, 'h10);
		settle;
		c.chain4 = 1'b0;
		c.odd_even = 1'b1;
		apply(c);
		issue_read(MODE_WORD, 'h11);
		issue_read(MODE_DWORD, 'h1C);
		settle;

		// random phases, one setting each, sharing the item budget
		for (ph = 0; ph < PHASES; ph++) begin
			apply(pick_settings(ph));
			steady <= (ph == 4);
			while (items_sent < (ph + 1) * TOTAL_ITEMS / PHASES) begin
				kind = $urandom_range(0, 3);
				if (kind == MODE_LOAD)
					store(($urandom_range(0, 4) < 3) ? $urandom_range(0, 63) :
						$urandom_range(0, 'h1FFFF), $urandom_range(0, 3), $urandom_range(0, 255));
				else
					issue_read(MODE_W'(kind), pick_offset());
			end
			settle;
			steady <= 1'b0;
		end

		if (errors == 0)
			$display("vga_planar_memory_read_core_tb passed");
		else
			$display("vga_planar_memory_read_core_tb failed");
		$finish;
	end

endmodule
